// ===== rtl/ddo_pkg.sv =====
// Package for the differential-drive odometry unit.
// Holds the state encoding, fixed-point constants, the CORDIC arctangent table and helpers.
// No dependencies.
package ddo_pkg;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MUL    = 6'b000010,
    S_ACC    = 6'b000100,
    S_CORDIC = 6'b001000,
    S_DIV    = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  // Steps of the shared multiplier.
  typedef enum logic [2:0] {
    M_DIST = 3'd0,
    M_DWM  = 3'd1,
    M_DTH  = 3'd2,
    M_DYAW = 3'd3,
    M_POSX = 3'd4,
    M_POSY = 3'd5,
    M_VLIN = 3'd6,
    M_VANG = 3'd7
  } mstep_t;

  typedef enum logic [1:0] {
    R_COUNT_SCALE = 2'd0,
    R_INV_TRACK   = 2'd1,
    R_TICK_RATE   = 2'd2
  } reg_idx_t;

  localparam logic [23:0] COUNT_SCALE_RST = 24'd97090;
  localparam logic [23:0] INV_TRACK_RST   = 24'd204800;
  localparam logic [29:0] TICK_RATE_RST   = 30'd1000000;
  localparam logic [31:0] BAM_PER_RAD     = 32'd683565276;
  localparam logic [33:0] CORDIC_X0       = 34'd652032874;

  function automatic logic [31:0] atan_bam(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -68'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== rtl/differential_drive_odometry_unit.sv =====
// Differential-drive odometry top level; depends on ddo_pkg and ddo_div.
// The time per transaction is set by the shared multiplier, the CORDIC loop and two divisions;
// the divisions are skipped when the elapsed time is zero.
// A new transaction is taken only once the last one is through: in_tready is high only in idle, and
// a result waiting on out_tready delays the return to idle.
// Synchronous active-low reset clears pose, counts and control and loads register defaults.
module differential_drive_odometry_unit #(
  parameter int COUNT_WIDTH     = 32,
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // left_count, right_count, elapsed_ticks
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata,  // pos_x, pos_y, heading, linear_speed, angular_speed
  output logic         out_tuser,  // no_elapsed_time
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [29:0]  cfg_data
);

  localparam int IW = $clog2(TRIG_ITERATIONS);

  ddo_pkg::state_t state_r, state_nxt;
  ddo_pkg::mstep_t mstep_r;

  logic [23:0] cs_r, itw_r;
  logic [29:0] tr_r;

  logic [COUNT_WIDTH-1:0] last_l_r, last_r_r;
  logic signed [31:0] x_r, y_r;
  logic [31:0] yaw_r;

  logic signed [33:0] sum_r, diff_r;
  logic [31:0] et_r;
  logic signed [31:0] dist_r, dwm_r, dth_r;
  logic [31:0] dyaw_r;
  logic signed [33:0] c_r, s_r;
  logic signed [31:0] vlin_r, vang_r;
  logic signed [66:0] prod_r;

  logic signed [33:0] cx_r, cy_r;
  logic signed [32:0] cz_r;
  logic [IW-1:0] iter_r;

  logic [159:0] out_data_r;
  logic out_user_r, out_valid_r;

  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [67:0] pext;
  logic signed [33:0] cxn, cyn;
  logic signed [32:0] czn, atan_s;
  logic signed [COUNT_WIDTH-1:0] dl, dr;
  logic div_start, div_done;
  logic signed [31:0] div_quo;

  assign in_tready  = state_r == ddo_pkg::S_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign pext       = 68'(prod_r);

  assign dl = in_tdata[COUNT_WIDTH-1:0] - last_l_r;
  assign dr = in_tdata[32+COUNT_WIDTH-1:32] - last_r_r;

  always_comb begin
    case (mstep_r)
      ddo_pkg::M_DIST: begin mul_a = sum_r;       mul_b = $signed({9'b0, cs_r}); end
      ddo_pkg::M_DWM:  begin mul_a = diff_r;      mul_b = $signed({9'b0, cs_r}); end
      ddo_pkg::M_DTH:  begin mul_a = 34'(dwm_r);  mul_b = $signed({9'b0, itw_r}); end
      ddo_pkg::M_DYAW: begin mul_a = 34'(dth_r);  mul_b = $signed({1'b0, ddo_pkg::BAM_PER_RAD}); end
      ddo_pkg::M_POSX: begin mul_a = c_r;         mul_b = 33'(dist_r); end
      ddo_pkg::M_POSY: begin mul_a = s_r;         mul_b = 33'(dist_r); end
      ddo_pkg::M_VLIN: begin mul_a = 34'(dist_r); mul_b = $signed({3'b0, tr_r}); end
      ddo_pkg::M_VANG: begin mul_a = 34'(dth_r);  mul_b = $signed({3'b0, tr_r}); end
      default:         begin mul_a = '0;          mul_b = '0; end
    endcase
  end

  // One CORDIC rotation per cycle on the shift-add datapath.
  always_comb begin
    atan_s = $signed({1'b0, ddo_pkg::atan_bam(5'(iter_r))});
    if (!cz_r[32]) begin
      cxn = cx_r - (cy_r >>> iter_r);
      cyn = cy_r + (cx_r >>> iter_r);
      czn = cz_r - atan_s;
    end else begin
      cxn = cx_r + (cy_r >>> iter_r);
      cyn = cy_r - (cx_r >>> iter_r);
      czn = cz_r + atan_s;
    end
  end

  assign div_start = state_r == ddo_pkg::S_ACC &&
                     (mstep_r == ddo_pkg::M_VLIN || mstep_r == ddo_pkg::M_VANG);

  ddo_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod_r),
    .den   (et_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ddo_pkg::S_IDLE:   if (in_tvalid) state_nxt = ddo_pkg::S_MUL;
      ddo_pkg::S_MUL:    state_nxt = ddo_pkg::S_ACC;
      ddo_pkg::S_ACC: begin
        case (mstep_r)
          ddo_pkg::M_DYAW: state_nxt = ddo_pkg::S_CORDIC;
          ddo_pkg::M_POSY: state_nxt = (et_r == '0) ? ddo_pkg::S_DONE : ddo_pkg::S_MUL;
          ddo_pkg::M_VLIN, ddo_pkg::M_VANG: state_nxt = ddo_pkg::S_DIV;
          default:         state_nxt = ddo_pkg::S_MUL;
        endcase
      end
      ddo_pkg::S_CORDIC: if (iter_r == IW'(TRIG_ITERATIONS - 1)) state_nxt = ddo_pkg::S_MUL;
      ddo_pkg::S_DIV: begin
        if (div_done)
          state_nxt = (mstep_r == ddo_pkg::M_VANG) ? ddo_pkg::S_DONE : ddo_pkg::S_MUL;
      end
      ddo_pkg::S_DONE:   if (!out_valid_r || out_tready) state_nxt = ddo_pkg::S_IDLE;
      default:           state_nxt = ddo_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ddo_pkg::S_IDLE;
      mstep_r     <= ddo_pkg::M_DIST;
      cs_r        <= ddo_pkg::COUNT_SCALE_RST;
      itw_r       <= ddo_pkg::INV_TRACK_RST;
      tr_r        <= ddo_pkg::TICK_RATE_RST;
      last_l_r    <= '0;
      last_r_r    <= '0;
      x_r         <= '0;
      y_r         <= '0;
      yaw_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          ddo_pkg::R_COUNT_SCALE: cs_r  <= cfg_data[23:0];
          ddo_pkg::R_INV_TRACK:   itw_r <= cfg_data[23:0];
          ddo_pkg::R_TICK_RATE:   tr_r  <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid_r && out_tready && state_r != ddo_pkg::S_DONE) out_valid_r <= 1'b0;

      case (state_r)
        ddo_pkg::S_IDLE: begin
          if (in_tvalid) begin
            last_l_r <= in_tdata[COUNT_WIDTH-1:0];
            last_r_r <= in_tdata[32+COUNT_WIDTH-1:32];
            sum_r    <= 34'(dl) + 34'(dr);
            diff_r   <= 34'(dr) - 34'(dl);
            et_r     <= in_tdata[95:64];
            mstep_r  <= ddo_pkg::M_DIST;
          end
        end
        ddo_pkg::S_MUL: prod_r <= mul_a * mul_b;
        ddo_pkg::S_ACC: begin
          case (mstep_r)
            ddo_pkg::M_DIST: begin
              dist_r  <= ddo_pkg::sat32((pext + 68'sd256) >>> 9);
              mstep_r <= ddo_pkg::M_DWM;
            end
            ddo_pkg::M_DWM: begin
              dwm_r   <= ddo_pkg::sat32((pext + 68'sd128) >>> 8);
              mstep_r <= ddo_pkg::M_DTH;
            end
            ddo_pkg::M_DTH: begin
              dth_r   <= ddo_pkg::sat32((pext + 68'sd32768) >>> 16);
              mstep_r <= ddo_pkg::M_DYAW;
            end
            ddo_pkg::M_DYAW: begin
              dyaw_r <= 32'((pext + 68'sd32768) >>> 16);
              cx_r   <= $signed(ddo_pkg::CORDIC_X0);
              cy_r   <= '0;
              cz_r   <= $signed({3'b000, yaw_r[29:0]});
              iter_r <= '0;
            end
            ddo_pkg::M_POSX: begin
              x_r     <= ddo_pkg::sat32(68'(x_r) + ((pext + 68'sd536870912) >>> 30));
              mstep_r <= ddo_pkg::M_POSY;
            end
            ddo_pkg::M_POSY: begin
              y_r     <= ddo_pkg::sat32(68'(y_r) + ((pext + 68'sd536870912) >>> 30));
              vlin_r  <= '0;
              vang_r  <= '0;
              mstep_r <= ddo_pkg::M_VLIN;
            end
            default: ;
          endcase
        end
        ddo_pkg::S_CORDIC: begin
          cx_r   <= cxn;
          cy_r   <= cyn;
          cz_r   <= czn;
          iter_r <= iter_r + IW'(1);
          if (iter_r == IW'(TRIG_ITERATIONS - 1)) begin
            // Map the first-quadrant rotation back by the old heading's quadrant.
            case (yaw_r[31:30])
              2'd0:    begin c_r <= cxn;  s_r <= cyn;  end
              2'd1:    begin c_r <= -cyn; s_r <= cxn;  end
              2'd2:    begin c_r <= -cxn; s_r <= -cyn; end
              default: begin c_r <= cyn;  s_r <= -cxn; end
            endcase
            yaw_r   <= yaw_r + dyaw_r;
            mstep_r <= ddo_pkg::M_POSX;
          end
        end
        ddo_pkg::S_DIV: begin
          if (div_done) begin
            if (mstep_r == ddo_pkg::M_VLIN) begin
              vlin_r  <= div_quo;
              mstep_r <= ddo_pkg::M_VANG;
            end else begin
              vang_r  <= div_quo;
            end
          end
        end
        ddo_pkg::S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {vang_r, vlin_r, yaw_r, y_r, x_r};
            out_user_r  <= et_r == '0;
            out_valid_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  a_accept_starts_dist: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == ddo_pkg::S_MUL && mstep_r == ddo_pkg::M_DIST)
    else $error("accepted transaction did not start the travel multiply");

  a_div_needs_time: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> et_r != '0)
    else $error("division started with zero elapsed time");

  a_cordic_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ddo_pkg::S_CORDIC |-> iter_r <= IW'(TRIG_ITERATIONS - 1))
    else $error("CORDIC iteration count overran");

  a_result_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ddo_pkg::S_DONE && et_r == '0 |-> vlin_r == '0 && vang_r == '0)
    else $error("speeds not zero for zero elapsed time");

endmodule

// ===== rtl/ddo_div.sv =====
// Bit-serial restoring divider for the speed terms, rounding to nearest, ties away from zero.
// Result saturates to signed 32 bits. Standalone, with no package dependencies.
module ddo_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [66:0]  num,
  input  logic        [31:0]  den,
  output logic                done,
  output logic signed [31:0]  quo
);

  logic        run_r;
  logic        done_r;
  logic        neg_r;
  logic        ovf_r;
  logic [32:0] rem_r;
  logic [32:0] nsh_r;
  logic [32:0] q_r;
  logic [5:0]  cnt_r;

  logic [66:0] mag;
  logic [63:0] nrm;
  logic [32:0] trial;
  logic        ge;

  always_comb begin
    mag   = num[66] ? 67'(-num) : 67'(num);
    nrm   = mag[63:0] + 64'(den >> 1);
    trial = {rem_r[31:0], nsh_r[32]};
    ge    = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        neg_r <= num[66];
        // Quotients of 2^33 and above saturate anyway.
        ovf_r <= {1'b0, nrm[63:33]} >= den;
        rem_r <= {2'b00, nrm[63:33]};
        nsh_r <= nrm[32:0];
        q_r   <= '0;
        cnt_r <= '0;
      end else if (run_r) begin
        rem_r <= ge ? trial - {1'b0, den} : trial;
        q_r   <= {q_r[31:0], ge};
        nsh_r <= {nsh_r[31:0], 1'b0};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd32) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (ovf_r || q_r >= 33'h080000000) quo = neg_r ? 32'sh80000000 : 32'sh7FFFFFFF;
    else quo = neg_r ? -$signed(q_r[31:0]) : $signed(q_r[31:0]);
  end

  assign done = done_r;

endmodule

// ===== test/differential_drive_odometry_unit_test.sv =====
// Self-checking testbench for differential_drive_odometry_unit: drives encoder counts and
// elapsed ticks, predicts pose and speeds in a scoreboard class and compares every result.
// Depends on ddo_pkg and the RTL of the odometry unit.
`timescale 1ns / 100ps

module differential_drive_odometry_unit_test;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        heading;
    logic signed [31:0] linear_speed;
    logic signed [31:0] angular_speed;
    logic               no_elapsed_time;
  } pose_t;

  class odometry_scoreboard;
    logic [23:0] count_scale;
    logic [23:0] inv_track;
    logic [29:0] tick_rate;
    logic [31:0] prev_left, prev_right, yaw;
    logic signed [31:0] x_pos, y_pos;
    pose_t pending_poses[$];
    int errors;
    longint arctan[24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

    function new();
      count_scale = ddo_pkg::COUNT_SCALE_RST;
      inv_track = ddo_pkg::INV_TRACK_RST;
      tick_rate = ddo_pkg::TICK_RATE_RST;
      prev_left = 0; prev_right = 0; yaw = 0; x_pos = 0; y_pos = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [29:0] val);
      case (idx)
        ddo_pkg::R_COUNT_SCALE: count_scale = val[23:0];
        ddo_pkg::R_INV_TRACK:   inv_track = val[23:0];
        ddo_pkg::R_TICK_RATE:   tick_rate = val;
        default: ;
      endcase
    endfunction

    function longint round_shr(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // Rounds to nearest with ties away from zero.
    function longint div_nearest(longint num, longint unsigned den);
      longint unsigned mag, q;
      mag = num < 0 ? longint'(-num) : num;
      q = (mag + den / 2) / den;
      return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function void note_input(logic [31:0] left, logic [31:0] right, logic [31:0] ticks);
      longint dl, dr, travel, dwm, dth, dyaw, cx, cy, nx, z, c, s;
      pose_t p;
      dl = longint'($signed(left - prev_left));
      dr = longint'($signed(right - prev_right));
      prev_left = left;
      prev_right = right;
      travel = clamp32(round_shr((dl + dr) * longint'(count_scale), 9));
      dwm = clamp32(round_shr((dr - dl) * longint'(count_scale), 8));
      dth = clamp32(round_shr(dwm * longint'(inv_track), 16));
      dyaw = round_shr(dth * longint'(ddo_pkg::BAM_PER_RAD), 16);
      // Rotate within the quadrant, then map the quadrant from the top two angle bits.
      cx = 652032874; cy = 0; z = longint'(yaw[29:0]);
      for (int i = 0; i < 16; i++) begin
        if (z >= 0) begin
          nx = cx - (cy >>> i); cy = cy + (cx >>> i); z -= arctan[i];
        end else begin
          nx = cx + (cy >>> i); cy = cy - (cx >>> i); z += arctan[i];
        end
        cx = nx;
      end
      case (yaw[31:30])
        2'd0: begin c = cx;  s = cy;  end
        2'd1: begin c = -cy; s = cx;  end
        2'd2: begin c = -cx; s = -cy; end
        default: begin c = cy; s = -cx; end
      endcase
      x_pos = 32'(clamp32(longint'(x_pos) + round_shr(travel * c, 30)));
      y_pos = 32'(clamp32(longint'(y_pos) + round_shr(travel * s, 30)));
      yaw = yaw + dyaw[31:0];
      p.pos_x = x_pos;
      p.pos_y = y_pos;
      p.heading = yaw;
      p.no_elapsed_time = (ticks == 0);
      p.linear_speed = 0;
      p.angular_speed = 0;
      if (ticks != 0) begin
        p.linear_speed = 32'(clamp32(div_nearest(travel * longint'(tick_rate), ticks)));
        p.angular_speed = 32'(clamp32(div_nearest(dth * longint'(tick_rate), ticks)));
      end
      pending_poses.push_back(p);
    endfunction

    function void check_result(logic [159:0] data, logic flag);
      pose_t e;
      if (pending_poses.size() == 0) begin
        $error("result arrived with no expectation pending");
        errors++;
        return;
      end
      e = pending_poses.pop_front();
      if (data[31:0] !== e.pos_x) begin
        $error("pos_x: expected %0d, got %0d", e.pos_x, $signed(data[31:0])); errors++;
      end
      if (data[63:32] !== e.pos_y) begin
        $error("pos_y: expected %0d, got %0d", e.pos_y, $signed(data[63:32])); errors++;
      end
      if (data[95:64] !== e.heading) begin
        $error("heading: expected %0h, got %0h", e.heading, data[95:64]); errors++;
      end
      if (data[127:96] !== e.linear_speed) begin
        $error("linear_speed: expected %0d, got %0d", e.linear_speed,
               $signed(data[127:96])); errors++;
      end
      if (data[159:128] !== e.angular_speed) begin
        $error("angular_speed: expected %0d, got %0d", e.angular_speed,
               $signed(data[159:128])); errors++;
      end
      if (flag !== e.no_elapsed_time) begin
        $error("no_elapsed_time: expected %0b, got %0b", e.no_elapsed_time, flag); errors++;
      end
    endfunction
  endclass

  logic         clk, rst_n;
  logic         in_tvalid, in_tready;
  logic [95:0]  in_tdata;   // left_count, right_count, elapsed_ticks
  logic         out_tvalid, out_tready;
  logic [159:0] out_tdata;  // pos_x, pos_y, heading, linear_speed, angular_speed
  logic         out_tuser;  // no_elapsed_time
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [29:0]  cfg_data;

  odometry_scoreboard sb = new();
  logic [31:0] last_l, last_r;
  int  hold_cycles;
  bit  quiet;

  differential_drive_odometry_unit dut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: random stalls, plus long hold-offs requested by the stimulus.
  initial begin
    out_tready = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_tready <= 0;
        hold_cycles = $urandom_range(0, 4);
      end else begin
        out_tready <= 1;
      end
    end
  end

  task automatic send_counts(logic [31:0] l, logic [31:0] r, logic [31:0] t);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {t, r, l};
    do @(posedge clk); while (!in_tready);
    sb.note_input(l, r, t);
    last_l = l;
    last_r = r;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending_poses.size() != 0) @(posedge clk);
    repeat (110) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [29:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic random_items(int n);
    logic [31:0] l, r, t;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        l = $urandom; r = $urandom; t = $urandom;
      end else begin
        l = last_l + $urandom_range(0, 4000) - 2000;
        r = last_r + $urandom_range(0, 4000) - 2000;
        case ($urandom_range(0, 9))
          0: t = 0;
          1: t = $urandom_range(1, 3);
          default: t = $urandom_range(100, 50000);
        endcase
      end
      send_counts(l, r, t);
    end
  endtask

  initial begin
    rst_n = 0; in_tvalid = 0; in_tdata = '0;
    cfg_we = 0; cfg_index = ddo_pkg::R_COUNT_SCALE; cfg_data = '0;
    hold_cycles = 0; quiet = 0; last_l = 0; last_r = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: first item against zero counts, zero elapsed time, extreme counts and wraps.
    send_counts(32'd100, 32'd120, 32'd1000);
    send_counts(32'd200, 32'd200, 32'd0);
    send_counts(32'h7FFFFFFF, 32'h80000000, 32'd1);
    send_counts(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
    send_counts(32'hFFFFFFFF, 32'h00000000, 32'd1);
    send_counts(32'h00000001, 32'hFFFFFFFF, 32'h80000000);
    send_counts(32'h00000000, 32'h00000000, 32'd0);
    for (int i = 0; i < 8; i++)
      send_counts(last_l + 32'd500, last_r + 32'd2500, 32'd1000);
    drain();

    write_cfg(ddo_pkg::R_COUNT_SCALE, 30'hFFFFFF);
    write_cfg(ddo_pkg::R_INV_TRACK, 30'hFFFFFF);
    write_cfg(ddo_pkg::R_TICK_RATE, 30'd1000000000);
    write_cfg(REG_UNUSED, 30'h15555555);
    send_counts(32'h40000000, 32'hC0000000, 32'd1);
    send_counts(32'h00000000, 32'h00000000, 32'd1);
    // The receiver holds off while items keep coming, so the input must stall.
    hold_cycles = 400;
    random_items(200);
    drain();

    write_cfg(ddo_pkg::R_COUNT_SCALE, 30'd1);
    write_cfg(ddo_pkg::R_INV_TRACK, 30'd1);
    write_cfg(ddo_pkg::R_TICK_RATE, 30'd1);
    random_items(100);
    drain();
    random_items(100);
    drain();

    write_cfg(ddo_pkg::R_COUNT_SCALE, 30'd0);
    write_cfg(ddo_pkg::R_TICK_RATE, 30'd0);
    random_items(40);
    drain();

    write_cfg(ddo_pkg::R_COUNT_SCALE, 30'($urandom_range(1, 24'hFFFFFF)));
    write_cfg(ddo_pkg::R_INV_TRACK, 30'($urandom_range(1, 24'hFFFFFF)));
    write_cfg(ddo_pkg::R_TICK_RATE, 30'($urandom_range(1, 1000000000)));
    random_items(350);
    drain();

    write_cfg(ddo_pkg::R_COUNT_SCALE, 30'(ddo_pkg::COUNT_SCALE_RST));
    write_cfg(ddo_pkg::R_INV_TRACK, 30'(ddo_pkg::INV_TRACK_RST));
    write_cfg(ddo_pkg::R_TICK_RATE, ddo_pkg::TICK_RATE_RST);
    random_items(250);
    quiet = 1;
    random_items(150);
    drain();

    if (sb.errors == 0 && sb.pending_poses.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
